// File: design/swtq_pkg.sv
// shared types, constants and the wrap-safe time compare for the sorted wakeup timer queue
package swtq_pkg;

  localparam int MAX_TASKS = 16;
  localparam int TASK_W    = 4;
  localparam int TIME_W    = 32;
  localparam int COUNT_W   = 5;
  localparam int KIND_W    = 2;

  // stream payload widths, padded to whole bytes
  localparam int IN_FIELDS_W  = TASK_W + 2 * TIME_W;
  localparam int IN_DATA_W    = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_FIELDS_W = TASK_W + COUNT_W + 1;
  localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

  localparam logic [TASK_W-1:0] IDLE_TASK   = '0;
  localparam logic              MODE_INSERT = 1'b0;
  localparam logic              MODE_CHECK  = 1'b1;

  localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
  localparam logic [KIND_W-1:0] KIND_WOKEN  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_DONE   = 2'd2;

  // command applied to every cell of the chain in the same cycle
  typedef enum logic [1:0] {
    OP_HOLD,
    OP_INSERT,
    OP_POP
  } op_t;

  typedef struct packed {
    logic              valid;
    logic [TASK_W-1:0] task_id;
    logic [TIME_W-1:0] wake_time;
  } entry_t;

  localparam entry_t ENTRY_EMPTY = '0;

  typedef struct packed {
    op_t               op;
    logic [TASK_W-1:0] task_id;
    logic [TIME_W-1:0] wake_time;
  } chain_cmd_t;

  typedef struct packed {
    logic              head_valid;
    logic [TASK_W-1:0] head_task;
    logic [TIME_W-1:0] head_wake;
    logic              full;
  } status_t;

  // a is later than b when the wrapped difference is positive
  function automatic logic time_later(input logic [TIME_W-1:0] a,
                                      input logic [TIME_W-1:0] b);
    logic [TIME_W-1:0] d;
    d = a - b;
    return (d != '0) && !d[TIME_W-1];
  endfunction

endpackage

// File: design/swtq_cell.sv
// one queue cell: holds an entry, shifts right on insert and left on pop
module swtq_cell (
  input  logic                 clk,
  input  logic                 rst,
  input  swtq_pkg::chain_cmd_t cmd,
  input  swtq_pkg::entry_t     left_ent,
  input  swtq_pkg::entry_t     right_ent,
  input  logic                 sfx_in,
  input  logic                 prev_sfx,
  output swtq_pkg::entry_t     ent,
  output logic                 sfx_out
);
  import swtq_pkg::*;

  entry_t ent_next;
  logic   not_later;

  // this entry stays in front of the new one when some entry at or after it is not later
  assign not_later = ent.valid && !time_later(ent.wake_time, cmd.wake_time);
  assign sfx_out   = not_later | sfx_in;

  // next entry from the chain command
  always_comb begin
    ent_next = ent;
    case (cmd.op)
      OP_INSERT: begin
        if (!sfx_out) begin
          if (prev_sfx) begin
            ent_next.valid     = 1'b1;
            ent_next.task_id   = cmd.task_id;
            ent_next.wake_time = cmd.wake_time;
          end else begin
            ent_next = left_ent;
          end
        end
      end
      OP_POP:  ent_next = right_ent;
      default: ent_next = ent;
    endcase
  end

  // entry register, only the valid bit is reset
  always_ff @(posedge clk) begin
    if (rst) begin
      ent.valid <= 1'b0;
    end else begin
      ent.valid <= ent_next.valid;
    end
    ent.task_id   <= ent_next.task_id;
    ent.wake_time <= ent_next.wake_time;
  end

endmodule

// File: design/swtq_ctrl.sv
// sequencer: takes items, drives the cell chain and holds the result register
module swtq_ctrl (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [swtq_pkg::IN_DATA_W-1:0]      s_tdata,   // task_id, wake_time, now_time
  input  logic                                s_tuser,   // mode
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [swtq_pkg::OUT_DATA_W-1:0]     m_tdata,   // woken_task, ready_count, accepted
  output logic [swtq_pkg::KIND_W-1:0]         m_tuser,   // kind
  output logic                                m_tlast,
  input  swtq_pkg::status_t                   status,
  output swtq_pkg::chain_cmd_t                cmd
);
  import swtq_pkg::*;

  typedef enum logic [1:0] {
    IDLE,
    INSERT,
    CHECK
  } state_t;

  state_t              state;
  logic [TASK_W-1:0]   item_task;
  logic [TIME_W-1:0]   item_wake;
  logic [TIME_W-1:0]   item_now;
  logic [COUNT_W-1:0]  cnt;
  logic                out_valid;
  logic [KIND_W-1:0]   out_kind;
  logic [TASK_W-1:0]   out_task;
  logic [COUNT_W-1:0]  out_count;
  logic                out_acc;
  logic                out_last;

  logic out_free;
  logic due;
  logic refuse;

  assign out_free = !out_valid || m_tready;
  assign due      = status.head_valid && !time_later(status.head_wake, item_now);
  assign refuse   = (item_task == IDLE_TASK) || status.full;
  assign s_tready = (state == IDLE);

  // chain command
  always_comb begin
    cmd.op        = OP_HOLD;
    cmd.task_id   = item_task;
    cmd.wake_time = item_wake;
    if (state == INSERT && out_free && !refuse) begin
      cmd.op = OP_INSERT;
    end else if (state == CHECK && out_free && due) begin
      cmd.op = OP_POP;
    end
  end

  // state, item registers and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      out_valid <= 1'b0;
      cnt       <= '0;
    end else begin
      // result valid: set on a load, cleared once taken
      if ((state == INSERT || state == CHECK) && out_free) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
      case (state)
        IDLE: begin
          if (s_tvalid) begin
            item_task <= s_tdata[TASK_W-1:0];
            item_wake <= s_tdata[TASK_W +: TIME_W];
            item_now  <= s_tdata[TASK_W + TIME_W +: TIME_W];
            state     <= (s_tuser == MODE_CHECK) ? CHECK : INSERT;
          end
        end
        INSERT: begin
          if (out_free) begin
            out_kind  <= KIND_INSERT;
            out_task  <= '0;
            out_count <= '0;
            out_acc   <= !refuse;
            out_last  <= 1'b1;
            state     <= IDLE;
          end
        end
        CHECK: begin
          if (out_free) begin
            out_acc   <= 1'b0;
            if (due) begin
              out_kind  <= KIND_WOKEN;
              out_task  <= status.head_task;
              out_count <= '0;
              out_last  <= 1'b0;
              cnt       <= cnt + 1'b1;
            end else begin
              out_kind  <= KIND_DONE;
              out_task  <= '0;
              out_count <= cnt;
              out_last  <= 1'b1;
              cnt       <= '0;
              state     <= IDLE;
            end
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

  assign m_tvalid = out_valid;
  assign m_tuser  = out_kind;
  assign m_tlast  = out_last;
  assign m_tdata  = {{(OUT_DATA_W - OUT_FIELDS_W){1'b0}}, out_acc, out_count, out_task};

  // a pop needs a live head entry
  a_pop_has_head: assert property (@(posedge clk) disable iff (rst)
    cmd.op == OP_POP |-> status.head_valid)
    else $error("pop issued on empty chain");

  // never insert into a full chain
  a_insert_not_full: assert property (@(posedge clk) disable iff (rst)
    cmd.op == OP_INSERT |-> !status.full)
    else $error("insert issued on full chain");

  // the woken count is back to zero once a check finishes
  a_cnt_cleared: assert property (@(posedge clk) disable iff (rst)
    (state == CHECK && out_free && !due) |=> cnt == '0)
    else $error("woken count not cleared after check");

  // an accepted insert leaves the chain holding at least one entry
  a_insert_fills: assert property (@(posedge clk) disable iff (rst)
    cmd.op == OP_INSERT |=> status.head_valid)
    else $error("chain empty after insert");

endmodule

// File: design/sorted_wakeup_timer_queue.sv
// top level: chain of queue cells ordered by wake time plus the sequencer
// Insert: the transaction is taken in IDLE, then INSERT updates the chain and loads the answer.
// Check: the transaction is taken in IDLE, then CHECK loads one result per woken task and a
//   closing result; the chain pops one head entry per cycle while the output register is free.
// A new transaction is taken while the last result still waits in the output register.
// Synchronous reset empties the chain (valid bits only) and the sequencer; no clearing pass.
module sorted_wakeup_timer_queue (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [swtq_pkg::IN_DATA_W-1:0]  s_tdata,   // task_id, wake_time, now_time
  input  logic                            s_tuser,   // mode
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [swtq_pkg::OUT_DATA_W-1:0] m_tdata,   // woken_task, ready_count, accepted
  output logic [swtq_pkg::KIND_W-1:0]     m_tuser,   // kind
  output logic                            m_tlast
);
  import swtq_pkg::*;

  chain_cmd_t cmd;
  status_t    status;
  entry_t     ent [MAX_TASKS];
  logic       sfx [MAX_TASKS];

  // row of cells, each linked to its neighbors
  for (genvar i = 0; i < MAX_TASKS; i++) begin : g_cell
    entry_t left_ent;
    entry_t right_ent;
    logic   sfx_in;
    logic   prev_sfx;

    if (i == 0) begin : g_first
      assign left_ent = ENTRY_EMPTY;
      assign prev_sfx = 1'b1;
    end else begin : g_mid_left
      assign left_ent = ent[i-1];
      assign prev_sfx = sfx[i-1];
    end

    if (i == MAX_TASKS - 1) begin : g_last
      assign right_ent = ENTRY_EMPTY;
      assign sfx_in    = 1'b0;
    end else begin : g_mid_right
      assign right_ent = ent[i+1];
      assign sfx_in    = sfx[i+1];
    end

    swtq_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .cmd       (cmd),
      .left_ent  (left_ent),
      .right_ent (right_ent),
      .sfx_in    (sfx_in),
      .prev_sfx  (prev_sfx),
      .ent       (ent[i]),
      .sfx_out   (sfx[i])
    );
  end

  // head and fill status for the sequencer
  assign status.head_valid = ent[0].valid;
  assign status.head_task  = ent[0].task_id;
  assign status.head_wake  = ent[0].wake_time;
  assign status.full       = ent[MAX_TASKS-1].valid;

  swtq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast),
    .status   (status),
    .cmd      (cmd)
  );

endmodule

// File: bench/swtq_checker.sv
// checker for the sorted wakeup timer queue: predicts results and compares them
`timescale 1ns / 100ps

module swtq_checker
  import swtq_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  input  logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,   // task_id, wake_time, now_time
  input  logic                  s_tuser,   // mode
  input  logic                  m_tvalid,
  input  logic                  m_tready,
  input  logic [OUT_DATA_W-1:0] m_tdata,   // woken_task, ready_count, accepted
  input  logic [KIND_W-1:0]     m_tuser,   // kind
  input  logic                  m_tlast,
  output int                    errors,
  output int                    outstanding,
  output int                    inserts,
  output int                    refused,
  output int                    checks,
  output int                    woken
);

  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [TASK_W-1:0]  woken_task;
    logic [COUNT_W-1:0] ready_count;
    logic               accepted;
    logic               last;
  } wake_result_t;

  // sleeping tasks in wake order, as the block should hold them
  logic [TASK_W-1:0] sleeper_task [MAX_TASKS];
  logic [TIME_W-1:0] sleeper_wake [MAX_TASKS];
  int                sleepers;

  // results still owed by the block, oldest first
  wake_result_t awaited_results [$];

  initial begin
    errors      = 0;
    outstanding = 0;
    inserts     = 0;
    refused     = 0;
    checks      = 0;
    woken       = 0;
    sleepers    = 0;
  end

  // a wakes later than b when the wrapped difference is positive
  function automatic bit later_than(input logic [TIME_W-1:0] a, input logic [TIME_W-1:0] b);
    logic [TIME_W-1:0] d;
    d = a - b;
    return (d != '0) && !d[TIME_W-1];
  endfunction

  function automatic wake_result_t make_result(input logic [KIND_W-1:0] kind,
                                               input logic [TASK_W-1:0] task_id,
                                               input int count, input logic acc,
                                               input logic last);
    wake_result_t r;
    r.kind        = kind;
    r.woken_task  = task_id;
    r.ready_count = count[COUNT_W-1:0];
    r.accepted    = acc;
    r.last        = last;
    return r;
  endfunction

  // put a task to sleep behind every entry that does not wake later
  task automatic predict_insert(input logic [TASK_W-1:0] tid, input logic [TIME_W-1:0] wake);
    int pos;
    inserts++;
    if (tid == IDLE_TASK || sleepers >= MAX_TASKS) begin
      refused++;
      awaited_results.push_back(make_result(KIND_INSERT, '0, 0, 1'b0, 1'b1));
      return;
    end
    pos = sleepers;
    while (pos > 0 && later_than(sleeper_wake[pos-1], wake)) pos--;
    for (int i = sleepers; i > pos; i--) begin
      sleeper_task[i] = sleeper_task[i-1];
      sleeper_wake[i] = sleeper_wake[i-1];
    end
    sleeper_task[pos] = tid;
    sleeper_wake[pos] = wake;
    sleepers++;
    awaited_results.push_back(make_result(KIND_INSERT, '0, 0, 1'b1, 1'b1));
  endtask

  // wake every due task from the front, then close with the count
  task automatic predict_check(input logic [TIME_W-1:0] now);
    int ready;
    ready = 0;
    checks++;
    while (ready < sleepers && !later_than(sleeper_wake[ready], now)) begin
      awaited_results.push_back(make_result(KIND_WOKEN, sleeper_task[ready], 0, 1'b0, 1'b0));
      ready++;
    end
    for (int i = ready; i < sleepers; i++) begin
      sleeper_task[i-ready] = sleeper_task[i];
      sleeper_wake[i-ready] = sleeper_wake[i];
    end
    sleepers = sleepers - ready;
    woken    = woken + ready;
    awaited_results.push_back(make_result(KIND_DONE, '0, ready, 1'b0, 1'b1));
  endtask

  task automatic report_mismatch(input string what, input wake_result_t want,
                                 input wake_result_t got);
    errors++;
    if (errors <= 10)
      $display("%0t %s: expected kind %0d task %0d count %0d acc %0d last %0d, got kind %0d task %0d count %0d acc %0d last %0d",
               $time, what, want.kind, want.woken_task, want.ready_count, want.accepted,
               want.last, got.kind, got.woken_task, got.ready_count, got.accepted, got.last);
  endtask

  // output transactions are compared before the input of the same edge is predicted
  always @(posedge clk) begin : watch
    wake_result_t got;
    wake_result_t want;
    if (rst) begin
      sleepers = 0;
      awaited_results.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        got.kind        = m_tuser;
        got.woken_task  = m_tdata[TASK_W-1:0];
        got.ready_count = m_tdata[TASK_W +: COUNT_W];
        got.accepted    = m_tdata[TASK_W+COUNT_W];
        got.last        = m_tlast;
        if (awaited_results.size() == 0) begin
          report_mismatch("unexpected transaction", '0, got);
        end else begin
          want = awaited_results.pop_front();
          if (got.kind !== want.kind || got.woken_task !== want.woken_task ||
              got.ready_count !== want.ready_count || got.accepted !== want.accepted ||
              got.last !== want.last)
            report_mismatch("result mismatch", want, got);
        end
      end
      if (s_tvalid && s_tready) begin
        if (s_tuser == MODE_CHECK)
          predict_check(s_tdata[TASK_W+TIME_W +: TIME_W]);
        else
          predict_insert(s_tdata[TASK_W-1:0], s_tdata[TASK_W +: TIME_W]);
      end
    end
    outstanding = awaited_results.size();
  end

endmodule

// File: bench/sorted_wakeup_timer_queue_tb.sv
// testbench top for the sorted wakeup timer queue: stimulus, handshakes and verdict
`timescale 1ns / 100ps

module sorted_wakeup_timer_queue_tb;
  import swtq_pkg::*;

  localparam int HOLD_CYCLES = 400;
  localparam int STUCK_LIMIT = 3000;
  localparam int PAD_W       = IN_DATA_W - TASK_W - 2 * TIME_W;

  logic                  clk      = 1'b0;
  logic                  rst      = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata  = '0;   // task_id, wake_time, now_time
  logic                  s_tuser  = 1'b0; // mode
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;         // woken_task, ready_count, accepted
  logic [KIND_W-1:0]     m_tuser;         // kind
  logic                  m_tlast;

  int errors, outstanding, inserts, refused, checks, woken;

  bit quiet        = 1'b0;  // no random idling on either side while set
  int hold_req     = 0;     // bumped to ask the receiver for a long hold-off
  int holds_done   = 0;
  int hold_left    = 0;
  int stuck_cycles = 0;

  always #5 clk = ~clk;

  sorted_wakeup_timer_queue dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  swtq_checker chk (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tuser     (m_tuser),
    .m_tlast     (m_tlast),
    .errors      (errors),
    .outstanding (outstanding),
    .inserts     (inserts),
    .refused     (refused),
    .checks      (checks),
    .woken       (woken)
  );

  // receiver: random stalls, or a long counted hold-off on request
  always @(posedge clk) begin
    if (hold_left != 0) begin
      m_tready  <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (holds_done != hold_req) begin
      m_tready   <= 1'b0;
      hold_left  <= HOLD_CYCLES;
      holds_done <= holds_done + 1;
    end else begin
      m_tready <= quiet || ($urandom_range(99) >= 11);
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready))
      stuck_cycles <= 0;
    else
      stuck_cycles <= stuck_cycles + 1;
    if (stuck_cycles >= STUCK_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles", STUCK_LIMIT);
      $display("Regression FAIL");
      $finish;
    end
  end

  // offer one item and wait for its transaction
  task automatic offer(input logic mode, input logic [TASK_W-1:0] tid,
                       input logic [TIME_W-1:0] wake, input logic [TIME_W-1:0] now);
    while (!quiet && $urandom_range(99) < 11) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= mode;
    s_tdata  <= {{PAD_W{1'b0}}, now, wake, tid};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  // unused fields carry random values
  task automatic sleep_task(input logic [TASK_W-1:0] tid, input logic [TIME_W-1:0] wake);
    offer(MODE_INSERT, tid, wake, $urandom());
  endtask

  task automatic check_now(input logic [TIME_W-1:0] now);
    offer(MODE_CHECK, TASK_W'($urandom_range(15)), $urandom(), now);
  endtask

  initial begin : stimulus
    logic [TIME_W-1:0] tick;
    logic [TIME_W-1:0] base;
    logic [TIME_W-1:0] wake;
    logic [TASK_W-1:0] tid;
    int                r;
    int                pick;

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: empty check, idle task, wrap extremes, duplicates and equal times
    check_now($urandom());
    sleep_task(IDLE_TASK, 32'h0000_1000);
    sleep_task(4'd15, 32'hFFFF_FFFF);
    sleep_task(4'd1, 32'h0000_0000);
    sleep_task(4'd8, 32'h7FFF_FFFF);
    sleep_task(4'd4, 32'h8000_0000);
    sleep_task(4'd7, 32'd100);
    sleep_task(4'd7, 32'd100);
    sleep_task(4'd2, 32'd100);
    check_now(32'd99);
    check_now(32'd100);
    check_now(32'h7FFF_FFFF);
    check_now(32'hFFFF_FFFF);
    check_now(32'h8000_0000);
    check_now(32'h0000_0000);

    // drain, then fill past full while the output is held off
    check_now(32'h4000_0000);
    check_now(32'hC000_0000);
    check_now(32'h4000_0000);
    check_now(32'hC000_0000);
    hold_req <= hold_req + 1;
    base = $urandom();
    for (int k = 0; k < 18; k++)
      sleep_task(TASK_W'(1 + k % 15), base + $urandom_range(64));
    check_now(base + 64);

    // random: mostly sleeps near a moving clock that rolls over, plus checks
    tick = 32'hFFFF_F000 + $urandom_range(2048);
    for (int n = 0; n < 290; n++) begin
      quiet <= (n >= 120 && n < 175);
      r = $urandom_range(99);
      if (r < 55) begin
        tid  = ($urandom_range(19) == 0) ? IDLE_TASK : TASK_W'($urandom_range(1, 15));
        pick = $urandom_range(9);
        if (pick < 7)
          wake = tick + $urandom_range(300);
        else if (pick < 8)
          wake = tick - $urandom_range(50);
        else
          wake = $urandom();
        sleep_task(tid, wake);
      end else if (r < 92) begin
        tick = tick + $urandom_range(150);
        check_now(tick);
      end else begin
        check_now($urandom());
      end
    end

    // let every owed result drain, then a short tail
    s_tvalid <= 1'b0;
    quiet    <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (25) @(posedge clk);

    $display("covered %0d sleep requests (%0d refused) and %0d expiry checks",
             inserts, refused, checks);
    $display("%0d tasks woken, %0d mismatches", woken, errors);
    if (errors == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
